[src/median_select_core_macros.svh]
// Assertion macros shared by the median select RTL.
`ifndef MEDIAN_SELECT_CORE_MACROS_SVH
`define MEDIAN_SELECT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MEDSEL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MEDSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/medsel_pkg.sv]
`default_nettype none

package medsel_pkg;

  // Fixed field widths
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  // Insertion sequencer states
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SHIFT   = 4'b0010,
    ST_MED_RD  = 4'b0100,
    ST_MED_OUT = 4'b1000
  } medsel_state_t;

endpackage

`default_nettype wire

[src/medsel_if.sv]
`default_nettype none

// Input channel: one set element per transfer
interface medsel_in_if import medsel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// Result channel: one median per set
interface medsel_out_if import medsel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] median;
  logic [COUNT_W-1:0]       count;
  logic                     overflow;

  modport source (output valid, median, count, overflow, input ready);
  modport sink   (input valid, median, count, overflow, output ready);
endinterface

`default_nettype wire

[src/medsel_ram.sv]
`default_nettype none

// Simple dual-port store: one write, one registered read per cycle
module medsel_ram import medsel_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0]      rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/median_select_core.sv]
// Median select: keeps a sorted store in one RAM, insertion shifts one entry a cycle.
// Elements are taken only in ST_IDLE; ST_SHIFT moves each larger kept element up, then
// writes the element; a marked last one then passes ST_MED_RD (median read) and
// ST_MED_OUT, which waits for a pending result to be taken, before out_valid rises.
// Reset: rst_n synchronous low clears state, fill count, overflow flag and output valid;
// the store itself is not cleared (only written entries are ever read).
`default_nettype none
`include "median_select_core_macros.svh"

module median_select_core import medsel_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  medsel_in_if.sink     in_ch,
  medsel_out_if.source  out_ch
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  medsel_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic          last_r, last_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] median_r, median_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic                     overflow_r, overflow_nxt;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]      pos_m1, pos_m2, fill_m1, mid;
  logic [CW+COUNT_W-1:0] fill_ext;

  assign pos_m1   = pos_r - ONE;
  assign pos_m2   = pos_r - TWO;
  assign fill_m1  = fill_r - ONE;
  assign mid      = fill_r >> 1;
  assign fill_ext = {{COUNT_W{1'b0}}, fill_r};

  medsel_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    res_count_nxt = res_count_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    median_nxt    = median_r;
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[AW-1:0];
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = pos_m1[AW-1:0];
    in_ch.ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          val_nxt  = in_ch.value;
          last_nxt = in_ch.last;
          pos_nxt  = fill_r;
          if (fill_r < MAX_CNT) begin
            // fetch the current top entry for the first compare
            if (fill_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = fill_m1[AW-1:0];
            end
            state_nxt = ST_SHIFT;
          end else begin
            // store full: drop the element
            ovf_nxt   = 1'b1;
            state_nxt = in_ch.last ? ST_MED_RD : ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        if (pos_r != '0 && ram_rdata > val_r) begin
          // move larger entry up, fetch the next one down
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_m1;
          if (pos_r >= TWO) begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2[AW-1:0];
          end
        end else begin
          // slot found
          ram_we    = 1'b1;
          ram_wdata = val_r;
          fill_nxt  = fill_r + ONE;
          state_nxt = last_r ? ST_MED_RD : ST_IDLE;
        end
      end
      ST_MED_RD: begin
        ram_re        = 1'b1;
        ram_raddr     = mid[AW-1:0];
        res_count_nxt = fill_ext[COUNT_W-1:0];
        res_ovf_nxt   = ovf_r;
        fill_nxt      = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = ST_MED_OUT;
      end
      ST_MED_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          median_nxt    = ram_rdata;
          count_nxt     = res_count_r;
          overflow_nxt  = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    res_count_r <= res_count_nxt;
    res_ovf_r   <= res_ovf_nxt;
    median_r    <= median_nxt;
    count_r     <= count_nxt;
    overflow_r  <= overflow_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.median   = median_r;
  assign out_ch.count    = count_r;
  assign out_ch.overflow = overflow_r;

  // checks
  `MEDSEL_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= MAX_CNT, "fill count above capacity")
  `MEDSEL_ASSERT_NOW(a_port_clash, ram_we && ram_re, ram_waddr != ram_raddr,
                     "RAM read/write clash")
  `MEDSEL_ASSERT_NOW(a_pos_bound, state_r == ST_SHIFT, pos_r <= fill_r && fill_r < MAX_CNT,
                     "insert position out of range")
  `MEDSEL_ASSERT_NEXT(a_drop_last,
                      in_ch.valid && in_ch.ready && in_ch.last && fill_r == MAX_CNT,
                      state_r == ST_MED_RD && ovf_r, "dropped last element not reported")

endmodule

`default_nettype wire
